### hdl/bxavg_pkg.sv
`default_nettype none
package bxavg_pkg;

   // fixed field and datapath widths
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_FACTOR  = 16;
   localparam int FACTOR_BITS = 5;
   localparam int POS_BITS    = 4;
   localparam int SUM_BITS    = 24;
   localparam int RECIP_BITS  = 33;
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam int WIDTH_BITS  = 13;
   localparam int CHAN_BITS   = 3;
   localparam int INDEX_BITS  = 2;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   // register indexes
   localparam logic [1:0] REG_BLOCK_FACTOR  = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

   // classified sample, front to back
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   first;
      logic                   last;
      logic [1:0]             chan;
      logic                   row_end;
   } cmd_type;

   // result beat
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] average;
      logic [1:0]             chan;
      logic                   row_end;
   } rsp_type;

   // ceil(2^32 / f^2): exact truncating divide for sums below 2^24
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [FACTOR_BITS-1:0] f);
      logic [RECIP_BITS-1:0] r;
      case (f)
         5'd1:    r = 33'h1_0000_0000;
         5'd2:    r = 33'h0_4000_0000;
         5'd3:    r = 33'h0_1C71_C71D;
         5'd4:    r = 33'h0_1000_0000;
         5'd5:    r = 33'h0_0A3D_70A4;
         5'd6:    r = 33'h0_071C_71C8;
         5'd7:    r = 33'h0_0539_782A;
         5'd8:    r = 33'h0_0400_0000;
         5'd9:    r = 33'h0_0329_1620;
         5'd10:   r = 33'h0_028F_5C29;
         5'd11:   r = 33'h0_021D_9EAE;
         5'd12:   r = 33'h0_01C7_1C72;
         5'd13:   r = 33'h0_0183_C978;
         5'd14:   r = 33'h0_014E_5E0B;
         5'd15:   r = 33'h0_0123_4568;
         5'd16:   r = 33'h0_0100_0000;
         default: r = 33'h1_0000_0000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/bxavg_ram.sv
`default_nettype none
module bxavg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port, read returns old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### hdl/bxavg_fifo.sv
`default_nettype none
module bxavg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           rdata,
   output logic                            empty,
   output logic                            full,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wptr_in  = do_push ? PW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = do_pop ? PW'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wptr_ff] <= wdata;
      end
   end

   assign rdata = data_ff[rptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign count = count_ff;

endmodule
`default_nettype wire

### hdl/bxavg_front.sv
`default_nettype none
module bxavg_front #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4,
   parameter int IB           = 14
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [bxavg_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [bxavg_pkg::WIDTH_BITS-1:0]     csr_wdata,
   input  wire logic                                 in_valid,
   input  wire logic [bxavg_pkg::SAMPLE_BITS-1:0]    in_sample,
   input  wire logic                                 in_frame_start,
   output logic                                      cmd_push,
   output logic      [IB-1:0]                        cmd_idx,
   output bxavg_pkg::cmd_type                        cmd,
   output logic      [bxavg_pkg::FACTOR_BITS-1:0]    factor
);

   localparam int PCW = $clog2(MAX_WIDTH+1);
   localparam int EW  = PCW + 2;
   localparam int CHW = $clog2(MAX_CHANNELS+1);
   localparam int FB  = bxavg_pkg::FACTOR_BITS;
   localparam int PB  = bxavg_pkg::POS_BITS;

   logic [FB-1:0]                    factor_ff;
   logic [bxavg_pkg::WIDTH_BITS-1:0] width_ff;
   logic [bxavg_pkg::CHAN_BITS-1:0]  chans_ff;

   logic [FB-1:0]  f_eff;
   logic [PCW-1:0] w_eff;
   logic [CHW-1:0] ch_eff;

   logic [PCW-1:0] pix_ff, pix_in, cur_pix;
   logic [CHW-1:0] chan_ff, chan_in, cur_chan;
   logic [PB-1:0]  rib_ff, rib_in, cur_rib;
   logic [PB-1:0]  cib_ff, cib_in, cur_cib;
   logic [IB-1:0]  base_ff, base_in, cur_base;
   logic [EW-1:0]  bstart_ff, bstart_in, cur_bstart;
   logic [EW-1:0]  cur_end;
   logic           restart;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FB'(2);
         width_ff  <= bxavg_pkg::WIDTH_BITS'(640);
         chans_ff  <= bxavg_pkg::CHAN_BITS'(3);
      end else if (csr_we) begin
         case (csr_index)
            bxavg_pkg::REG_BLOCK_FACTOR:  factor_ff <= csr_wdata[FB-1:0];
            bxavg_pkg::REG_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            bxavg_pkg::REG_CHANNEL_COUNT: chans_ff  <= csr_wdata[bxavg_pkg::CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_we && (csr_index == bxavg_pkg::REG_BLOCK_FACTOR ||
                               csr_index == bxavg_pkg::REG_IMAGE_WIDTH ||
                               csr_index == bxavg_pkg::REG_CHANNEL_COUNT);

   // clamp registers into the supported range
   always_comb begin
      if (factor_ff == '0)                        f_eff = FB'(1);
      else if (factor_ff > FB'(bxavg_pkg::MAX_FACTOR)) f_eff = FB'(bxavg_pkg::MAX_FACTOR);
      else                                        f_eff = factor_ff;
      if (width_ff == '0)                         w_eff = PCW'(1);
      else if (32'(width_ff) > MAX_WIDTH)         w_eff = PCW'(MAX_WIDTH);
      else                                        w_eff = PCW'(width_ff);
      if (chans_ff == '0)                         ch_eff = CHW'(1);
      else if (32'(chans_ff) > MAX_CHANNELS)      ch_eff = CHW'(MAX_CHANNELS);
      else                                        ch_eff = CHW'(chans_ff);
   end

   // position of this sample, frame start zeroes it
   always_comb begin
      cur_pix    = in_frame_start ? '0 : pix_ff;
      cur_chan   = in_frame_start ? '0 : chan_ff;
      cur_rib    = in_frame_start ? '0 : rib_ff;
      cur_cib    = in_frame_start ? '0 : cib_ff;
      cur_base   = in_frame_start ? '0 : base_ff;
      cur_bstart = in_frame_start ? '0 : bstart_ff;
      cur_end    = EW'(cur_bstart + EW'(f_eff));
   end

   // classify the sample
   always_comb begin
      cmd_push       = in_valid && (cur_end <= EW'(w_eff));
      cmd_idx        = IB'(cur_base + IB'(cur_chan));
      cmd.sample     = in_sample;
      cmd.first      = (cur_rib == '0) && (cur_cib == '0);
      cmd.last       = ({1'b0, cur_rib} == FB'(f_eff - 1'b1)) &&
                       ({1'b0, cur_cib} == FB'(f_eff - 1'b1));
      cmd.chan       = cur_chan[1:0];
      cmd.row_end    = (EW'(cur_end + EW'(f_eff)) > EW'(w_eff));
   end

   // advance the raster position
   always_comb begin
      pix_in    = cur_pix;
      chan_in   = CHW'(cur_chan + 1'b1);
      rib_in    = cur_rib;
      cib_in    = cur_cib;
      base_in   = cur_base;
      bstart_in = cur_bstart;
      if (CHW'(cur_chan + 1'b1) >= ch_eff) begin
         chan_in = '0;
         if ({1'b0, cur_cib} == FB'(f_eff - 1'b1)) begin
            cib_in    = '0;
            base_in   = IB'(cur_base + IB'(ch_eff));
            bstart_in = cur_end;
         end else begin
            cib_in = PB'(cur_cib + 1'b1);
         end
         pix_in = PCW'(cur_pix + 1'b1);
         if (PCW'(cur_pix + 1'b1) >= w_eff) begin
            pix_in    = '0;
            cib_in    = '0;
            base_in   = '0;
            bstart_in = '0;
            if ({1'b0, cur_rib} == FB'(f_eff - 1'b1)) rib_in = '0;
            else                                      rib_in = PB'(cur_rib + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pix_ff    <= '0;
         chan_ff   <= '0;
         rib_ff    <= '0;
         cib_ff    <= '0;
         base_ff   <= '0;
         bstart_ff <= '0;
      end else if (in_valid) begin
         pix_ff    <= pix_in;
         chan_ff   <= chan_in;
         rib_ff    <= rib_in;
         cib_ff    <= cib_in;
         base_ff   <= base_in;
         bstart_ff <= bstart_in;
      end
   end

   assign factor = f_eff;

`ifndef SYNTHESIS
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff < ch_eff) else $error("channel position out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cib_ff} < f_eff) else $error("column in block out of range");
`endif

endmodule
`default_nettype wire

### hdl/bxavg_back.sv
`default_nettype none
module bxavg_back #(
   parameter int IB    = 14,
   parameter int DEPTH = 16384
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   input  wire logic [IB-1:0]                     q_idx,
   input  wire bxavg_pkg::cmd_type                q_cmd,
   output logic                                   q_pop,
   input  wire logic [bxavg_pkg::FACTOR_BITS-1:0] factor,
   input  wire logic [$clog2(bxavg_pkg::OUT_DEPTH+1)-1:0] out_count,
   input  wire logic                              out_full,
   output logic                                   out_push,
   output bxavg_pkg::rsp_type                     div_beat
);

   localparam int SB = bxavg_pkg::SUM_BITS;
   localparam int OCW = $clog2(bxavg_pkg::OUT_DEPTH+1);

   logic                 s1_valid_ff, s1_fwd_ff, s1_fwd_in;
   logic [IB-1:0]        s1_idx_ff;
   bxavg_pkg::cmd_type   s1_cmd_ff;
   logic [SB-1:0]        acc_ff, acc_in, prev_sum, ram_rdata;

   logic                 s2_valid_ff;
   logic [1:0]           s2_chan_ff;
   logic                 s2_row_end_ff;

   logic                 s3_valid_ff;
   logic [1:0]           s3_chan_ff;
   logic                 s3_row_end_ff;
   logic [bxavg_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [OCW+1:0]       reserved;

   // take a command only if the result queue can absorb everything in flight
   always_comb begin
      reserved  = (OCW+2)'(out_count) + (OCW+2)'(s1_valid_ff) +
                  (OCW+2)'(s2_valid_ff) + (OCW+2)'(s3_valid_ff);
      q_pop     = !q_empty && (reserved < (OCW+2)'(bxavg_pkg::OUT_DEPTH));
      s1_fwd_in = s1_valid_ff && (s1_idx_ff == q_idx);
   end

   bxavg_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_sums (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_idx_ff),
      .wdata (acc_in),
      .re    (q_pop),
      .raddr (q_idx),
      .rdata (ram_rdata)
   );

   // accumulate, bypassing the sum written in the previous cycle
   always_comb begin
      prev_sum = s1_fwd_ff ? acc_ff : ram_rdata;
      acc_in   = s1_cmd_ff.first ? SB'(s1_cmd_ff.sample)
                                 : SB'(prev_sum + SB'(s1_cmd_ff.sample));
      prod_in  = bxavg_pkg::PROD_BITS'(acc_ff) *
                 bxavg_pkg::PROD_BITS'(bxavg_pkg::recip_of(factor));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= q_pop;
         s1_fwd_ff   <= q_pop && s1_fwd_in;
         s2_valid_ff <= s1_valid_ff && s1_cmd_ff.last;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_idx_ff <= q_idx;
         s1_cmd_ff <= q_cmd;
      end
      if (s1_valid_ff) begin
         acc_ff <= acc_in;
      end
      s2_chan_ff    <= s1_cmd_ff.chan;
      s2_row_end_ff <= s1_cmd_ff.row_end;
      prod_ff       <= prod_in;
      s3_chan_ff    <= s2_chan_ff;
      s3_row_end_ff <= s2_row_end_ff;
   end

   // divided sum to the result queue
   always_comb begin
      out_push         = s3_valid_ff;
      div_beat.average = prod_ff[bxavg_pkg::RECIP_SHIFT +: bxavg_pkg::SAMPLE_BITS];
      div_beat.chan    = s3_chan_ff;
      div_beat.row_end = s3_row_end_ff;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result queue overflow");
   a_s3_source: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> $past(s2_valid_ff)) else $error("result without a finished block");
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> $past(s1_valid_ff) && s1_valid_ff) else $error("bypass without a write");
`endif

endmodule
`default_nettype wire

### hdl/box_average_downscale_unit.sv
// channel  | direction | beat accepted when       | payload
// req      | in        | req_push && !req_full   | req_sample, req_frame_start
// rsp      | out       | rsp_pop && !rsp_empty   | rsp_average, rsp_channel_index, rsp_row_end
// csr      | in        | csr_we                  | csr_index, csr_wdata
//
// one sample per cycle sustained while rsp keeps draining; a finished block shows on rsp after
// its last sample is taken and has passed the command queue, sum memory read, add and multiply
// the sum memory port pair (one read, one write per cycle) sets the rate
// reset is synchronous; sum memory is not cleared, each block loads its first sample
// rsp stalls back up through the result queue and command queue to req_full
`default_nettype none
module box_average_downscale_unit #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [bxavg_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  wire logic                                 req_frame_start,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic      [bxavg_pkg::SAMPLE_BITS-1:0]    rsp_average,
   output logic      [1:0]                           rsp_channel_index,
   output logic                                      rsp_row_end,
   input  wire logic                                 csr_we,
   input  wire logic [bxavg_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [bxavg_pkg::WIDTH_BITS-1:0]     csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int IB    = $clog2(DEPTH);
   localparam int CMDW  = IB + $bits(bxavg_pkg::cmd_type);
   localparam int OCW   = $clog2(bxavg_pkg::OUT_DEPTH+1);

   logic                            in_valid;
   logic                            cmd_push;
   logic [IB-1:0]                   cmd_idx, q_idx;
   bxavg_pkg::cmd_type              cmd, q_cmd;
   logic [bxavg_pkg::FACTOR_BITS-1:0] factor;
   logic                            q_empty, q_full, q_pop;
   logic [$clog2(bxavg_pkg::CMD_DEPTH+1)-1:0] q_count;
   logic                            out_push, out_full;
   logic [OCW-1:0]                  out_count;
   bxavg_pkg::rsp_type              div_beat, rsp_data;

   assign in_valid = req_push && !q_full;
   assign req_full = q_full;

   // front: position counters and classification
   bxavg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS), .IB(IB)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_valid       (in_valid),
      .in_sample      (req_sample),
      .in_frame_start (req_frame_start),
      .cmd_push       (cmd_push),
      .cmd_idx        (cmd_idx),
      .cmd            (cmd),
      .factor         (factor)
   );

   // command queue between front and back
   bxavg_fifo #(.WIDTH(CMDW), .DEPTH(bxavg_pkg::CMD_DEPTH)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata ({cmd_idx, cmd}),
      .pop   (q_pop),
      .rdata ({q_idx, q_cmd}),
      .empty (q_empty),
      .full  (q_full),
      .count (q_count)
   );

   // back: accumulate and divide
   bxavg_back #(.IB(IB), .DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_idx     (q_idx),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .factor    (factor),
      .out_count (out_count),
      .out_full  (out_full),
      .out_push  (out_push),
      .div_beat  (div_beat)
   );

   // result queue
   bxavg_fifo #(.WIDTH($bits(bxavg_pkg::rsp_type)), .DEPTH(bxavg_pkg::OUT_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (div_beat),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty),
      .full  (out_full),
      .count (out_count)
   );

   assign rsp_average       = rsp_data.average;
   assign rsp_channel_index = rsp_data.chan;
   assign rsp_row_end       = rsp_data.row_end;

`ifndef SYNTHESIS
   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(bxavg_pkg::CMD_DEPTH+1))'(bxavg_pkg::CMD_DEPTH))
      else $error("command queue count out of range");
`endif

endmodule
`default_nettype wire

### dv/box_average_downscale_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module box_average_downscale_unit_tb;

   localparam int SB  = bxavg_pkg::SAMPLE_BITS;
   localparam int IXB = bxavg_pkg::INDEX_BITS;
   localparam int WB  = bxavg_pkg::WIDTH_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SUM_ENTRIES = 4096 * 4;
   localparam int RANDOM_ITEMS = 960;

   typedef struct packed {
      logic [SB-1:0] average;
      logic [1:0]    chan;
      logic          row_end;
   } avg_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [SB-1:0] req_sample = '0;
   logic req_frame_start = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [SB-1:0] rsp_average;
   logic [1:0] rsp_channel_index;
   logic rsp_row_end;
   logic csr_we = 1'b0;
   logic [IXB-1:0] csr_index = '0;
   logic [WB-1:0] csr_wdata = '0;

   box_average_downscale_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .req_frame_start(req_frame_start),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_average(rsp_average), .rsp_channel_index(rsp_channel_index),
      .rsp_row_end(rsp_row_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // prediction state
   int unsigned block_acc [SUM_ENTRIES];
   int unsigned col_pos, chan_pos, row_blk, col_blk;
   logic [4:0]  factor_reg = 5'd2;
   logic [12:0] width_reg = 13'd640;
   logic [2:0]  chans_reg = 3'd3;
   avg_beat_type pending_avgs [$];

   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   bit hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned items_sent = 0;

   always #1 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      chan_pos = 0;
      row_blk = 0;
      col_blk = 0;
   endfunction

   // box average of one accepted sample
   function automatic void predict_average(input logic [SB-1:0] s, input bit fs);
      int unsigned f, w, ch, bc, idx, acc;
      bit first, last;
      avg_beat_type beat;
      f = clamp_reg(factor_reg, 16);
      w = clamp_reg(width_reg, 4096);
      ch = clamp_reg(chans_reg, 4);
      if (fs) restart_frame();
      if (col_pos >= w) col_pos = 0;
      if (chan_pos >= ch) chan_pos = 0;
      if (row_blk >= f) row_blk = 0;
      if (col_blk >= f) col_blk = 0;
      bc = col_pos / f;
      idx = bc * ch + chan_pos;
      first = (row_blk == 0) && (col_blk == 0);
      last = (row_blk == f - 1) && (col_blk == f - 1);
      if ((bc * f + f) <= w && idx < SUM_ENTRIES) begin
         acc = first ? s : block_acc[idx] + s;
         block_acc[idx] = acc;
         if (last) begin
            beat.average = SB'(acc / (f * f));
            beat.chan = chan_pos[1:0];
            beat.row_end = ((bc + 2) * f > w);
            pending_avgs.push_back(beat);
         end
      end
      chan_pos++;
      if (chan_pos >= ch) begin
         chan_pos = 0;
         col_blk++;
         if (col_blk >= f) col_blk = 0;
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            col_blk = 0;
            row_blk++;
            if (row_blk >= f) row_blk = 0;
         end
      end
   endfunction

   // result checker and pop driver
   always @(posedge clock) begin : rsp_side
      avg_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_avgs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: avg %0d chan %0d row_end %0d",
                        rsp_average, rsp_channel_index, rsp_row_end);
         end else begin
            want = pending_avgs.pop_front();
            if (want.average !== rsp_average || want.chan !== rsp_channel_index ||
                want.row_end !== rsp_row_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp avg %0d chan %0d row_end %0d, got %0d %0d %0d",
                           want.average, want.chan, want.row_end,
                           rsp_average, rsp_channel_index, rsp_row_end);
            end
         end
      end
      // long hold-off counted here
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // one sample beat, with random idle ahead of it
   task automatic send_sample(input logic [SB-1:0] s, input bit fs);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample <= s;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_average(s, fs);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write while idle
   task automatic write_reg(input logic [IXB-1:0] idx, input logic [WB-1:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         bxavg_pkg::REG_BLOCK_FACTOR:  begin factor_reg = val[4:0]; restart_frame(); end
         bxavg_pkg::REG_IMAGE_WIDTH:   begin width_reg = val; restart_frame(); end
         bxavg_pkg::REG_CHANNEL_COUNT: begin chans_reg = val[2:0]; restart_frame(); end
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int unsigned f, input int unsigned w, input int unsigned ch);
      write_reg(bxavg_pkg::REG_BLOCK_FACTOR, WB'(f));
      write_reg(bxavg_pkg::REG_IMAGE_WIDTH, WB'(w));
      write_reg(bxavg_pkg::REG_CHANNEL_COUNT, WB'(ch));
   endtask

   function automatic logic [SB-1:0] random_sample();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return SB'($urandom);
      endcase
   endfunction

   // extremes, every channel, partial blocks, odd register writes
   task automatic test_directed();
      set_geometry(1, 3, 4);
      send_sample(16'h0000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      // unused index: no restart
      write_reg(2'd3, 13'h1FFF);
      send_sample(16'h0001, 1'b0);
      // partial trailing column dropped
      set_geometry(2, 3, 1);
      for (int i = 0; i < 6; i++) send_sample(16'hFFFF, i == 0);
      // out of range values clamp
      set_geometry(0, 0, 0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8001, 1'b0);
      set_geometry(31, 13'h1FFF, 7);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h0000, 1'b0);
      wait_drained();
   endtask

   // well-formed frames with random content, some broken by stray frame starts
   task automatic run_random_configs(input int unsigned budget);
      int unsigned f, w, ch, fe, we, ce, rows, start;
      start = items_sent;
      while (items_sent - start < budget) begin
         case ($urandom_range(9))
            0: f = $urandom_range(17, 31);
            1: f = 0;
            2: f = 16;
            default: f = $urandom_range(1, 4);
         endcase
         case ($urandom_range(9))
            0: w = 0;
            1: w = $urandom_range(4096, 8191);
            default: w = $urandom_range(1, 12);
         endcase
         case ($urandom_range(5))
            0: ch = $urandom_range(5, 7);
            1: ch = 0;
            default: ch = $urandom_range(1, 4);
         endcase
         set_geometry(f, w, ch);
         fe = clamp_reg(f, 16);
         we = clamp_reg(w, 4096);
         ce = clamp_reg(ch, 4);
         rows = $urandom_range(fe, 3 * fe);
         // wide images: only a couple of rows worth of budget
         while (rows > 1 && rows * we * ce > 200) rows--;
         for (int r = 0; r < rows; r++)
            for (int x = 0; x < we && r * we * ce + x * ce < 200; x++)
               for (int c = 0; c < ce; c++)
                  send_sample(random_sample(),
                              (r == 0 && x == 0 && c == 0) || ($urandom_range(99) < 2));
      end
   endtask

   task automatic test_random_phases();
      run_random_configs(RANDOM_ITEMS / 4);
      tx_idle_pct = 83;
      run_random_configs(RANDOM_ITEMS / 4);
      tx_idle_pct = 0;
      rx_stall_pct = 83;
      run_random_configs(RANDOM_ITEMS / 4);
      tx_idle_pct = 11;
      rx_stall_pct = 11;
      run_random_configs(RANDOM_ITEMS / 4);
      tx_idle_pct = 0;
      rx_stall_pct = 0;
   endtask

   // receiver holds off so the block fills and stalls its input
   task automatic test_backpressure();
      set_geometry(1, 5, 1);
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) send_sample(random_sample(), i == 0);
      wait_drained();
      for (int i = 0; i < 10; i++) send_sample(random_sample(), 1'b0);
   endtask

   initial begin
      for (int i = 0; i < SUM_ENTRIES; i++) block_acc[i] = 0;
      restart_frame();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phases();
      wait_drained();
      if (mismatches == 0 && pending_avgs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
